// File: rtl/core/i2crm_pkg.sv
// ----------------------------------------------------------------------------
// i2crm_pkg
// Shared types and constants of the I2C 16-bit register master: beat
// payloads, bus phases, configuration register indexes and reset values.
// ----------------------------------------------------------------------------
package i2crm_pkg;

    // Operation codes carried by an input beat
    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_DEV_ADDR = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TICKS    = 1'd1;
    localparam int unsigned CFG_DATA_W = 8;

    localparam logic [6:0] DEV_ADDR_RESET = 7'd46;
    localparam logic [7:0] TICKS_RESET    = 8'd1;

    typedef struct packed {
        logic [1:0]  operation;
        logic [7:0]  reg_address;
        logic [15:0] write_value;
        logic        sda_in;
    } i2crm_in_t;

    typedef struct packed {
        logic        scl_level;
        logic        sda_level;
        logic        sda_drive;
        logic        busy_res;
        logic        done_res;
        logic [15:0] read_value;
        logic        request_dropped;
    } i2crm_out_t;

    typedef enum logic [4:0] {
        PH_IDLE, PH_S0, PH_S1, PH_S2, PH_S3,
        PH_B0, PH_B1, PH_B2,
        PH_A0, PH_A1, PH_A2, PH_A3,
        PH_R0, PH_R1,
        PH_Q0, PH_Q1, PH_Q2, PH_Q3,
        PH_P0, PH_P1, PH_P2, PH_P3
    } phase_t;

    typedef enum logic [1:0] {
        EL_START, EL_WBYTE, EL_RBYTE, EL_STOP
    } elem_t;

    // Phase lengths in microsecond units
    typedef enum logic [1:0] {
        UNITS_1, UNITS_2, UNITS_6
    } units_t;

    typedef struct packed {
        phase_t      phase;
        logic [10:0] delay_count;
        logic [3:0]  bit_index;
        logic [2:0]  byte_index;
        logic [7:0]  shift_byte;
        logic        is_read;
        logic [7:0]  latched_register;
        logic [15:0] latched_value;
        logic [15:0] captured_value;
        logic        scl;
        logic        sda;
        logic        sda_drive;
    } eng_state_t;

endpackage

// File: rtl/core/i2c_register_master_unit.sv
// ----------------------------------------------------------------------------
// i2c_register_master_unit
// I2C master for 16-bit register writes and reads, advanced one tick beat at
// a time; every input beat yields exactly one result beat.
// ----------------------------------------------------------------------------
//
//  channel  | ports                              | carries
//  ---------+------------------------------------+-------------------------------
//  s_       | s_valid / s_ready / s_data         | tick: operation, register,
//           |                                    | write value, sampled SDA
//  m_       | m_valid / m_ready / m_data         | pin levels, busy, done,
//           |                                    | read value, dropped request
//  cfg_     | cfg_wr_en / cfg_index / cfg_wdata  | device address, ticks per us
//
//  One beat per cycle sustained while m_ready keeps the result register
//  draining; a beat passes through the input register, then the result register.
//  The sequencer step between the two registers is a single pass of phase
//  logic, so the bus phase counter decides nothing about throughput.
//  Reset (aresetn low, synchronous) empties both registers, returns the
//  sequencer to idle with all pins low/released, and loads address 46 and
//  one tick per microsecond.
//  A stalled m_ready holds the result and, once the input register is full,
//  holds s_ready low; nothing is dropped or repeated.
// ----------------------------------------------------------------------------
module i2c_register_master_unit (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  i2crm_pkg::i2crm_in_t                  s_data,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output i2crm_pkg::i2crm_out_t                 m_data,
    input  logic                                  cfg_wr_en,
    input  logic [i2crm_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [i2crm_pkg::CFG_DATA_W-1:0]      cfg_wdata
);
    import i2crm_pkg::*;

    logic [6:0] dev_addr_q_reg;
    logic [7:0] ticks_reg;
    logic       item_valid;
    i2crm_in_t  item;
    logic       space;
    logic       take;
    i2crm_out_t result;

    // Configuration: plain register writes, no read-back
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dev_addr_q_reg <= DEV_ADDR_RESET;
            ticks_reg      <= TICKS_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_DEV_ADDR: dev_addr_q_reg <= cfg_wdata[6:0];
                CFG_TICKS:    ticks_reg      <= cfg_wdata;
                default:      ticks_reg      <= ticks_reg;
            endcase
        end
    end

    // Advance the sequencer only when the result register can take the beat
    assign take = item_valid && space;

    i2crm_in_stage u_in_stage (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .take       (take),
        .item_valid (item_valid),
        .item       (item)
    );

    i2crm_engine u_engine (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .take         (take),
        .item         (item),
        .dev_addr     (dev_addr_q_reg),
        .ticks_per_us (ticks_reg),
        .result       (result)
    );

    i2crm_out_stage u_out_stage (
        .aclk    (aclk),
        .aresetn (aresetn),
        .load    (take),
        .data    (result),
        .space   (space),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

// File: rtl/core/i2crm_in_stage.sv
// ----------------------------------------------------------------------------
// i2crm_in_stage
// Input register: holds one tick beat until the engine consumes it.
// ----------------------------------------------------------------------------
module i2crm_in_stage (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  i2crm_pkg::i2crm_in_t s_data,
    input  logic                 take,
    output logic                 item_valid,
    output i2crm_pkg::i2crm_in_t item
);
    import i2crm_pkg::*;

    logic      valid_reg;
    logic      valid_next;
    i2crm_in_t item_reg;

    // Refill in the same cycle the held beat leaves
    assign s_ready    = !valid_reg || take;
    assign valid_next = (s_valid && s_ready) || (valid_reg && !take);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= s_data;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

// File: rtl/core/i2crm_engine.sv
// ----------------------------------------------------------------------------
// i2crm_engine
// Bus sequencer: state registers plus one tick of phase logic per beat.
// ----------------------------------------------------------------------------
module i2crm_engine (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  take,
    input  i2crm_pkg::i2crm_in_t  item,
    input  logic [6:0]            dev_addr,
    input  logic [7:0]            ticks_per_us,
    output i2crm_pkg::i2crm_out_t result
);
    import i2crm_pkg::*;

    // Byte slots within a transaction plan
    localparam logic [2:0] SLOT_ADDR   = 3'd1;
    localparam logic [2:0] SLOT_REG    = 3'd2;
    localparam logic [2:0] SLOT_HIGH   = 3'd3;
    localparam logic [2:0] SLOT_RADDR  = 3'd4;
    localparam logic [2:0] SLOT_RDHIGH = 3'd5;
    localparam logic [2:0] SLOT_RDLOW  = 3'd6;

    eng_state_t state_reg;
    eng_state_t state_next;

    function automatic logic [10:0] phase_ticks(input units_t u, input logic [7:0] tpu);
        logic [7:0] t;
        logic [10:0] n;
        t = (tpu == 8'd0) ? 8'd1 : tpu;
        case (u)
            UNITS_1: n = {3'b000, t};
            UNITS_2: n = {2'b00, t, 1'b0};
            UNITS_6: n = {1'b0, t, 2'b00} + {2'b00, t, 1'b0};
            default: n = {3'b000, t};
        endcase
        return n;
    endfunction

    function automatic elem_t plan_kind(input logic rd, input logic [2:0] idx);
        elem_t k;
        if (rd) begin
            case (idx)
                3'd0:    k = EL_START;
                3'd1:    k = EL_WBYTE;
                3'd2:    k = EL_WBYTE;
                3'd3:    k = EL_START;
                3'd4:    k = EL_WBYTE;
                3'd5:    k = EL_RBYTE;
                3'd6:    k = EL_RBYTE;
                default: k = EL_STOP;
            endcase
        end else begin
            case (idx)
                3'd0:    k = EL_START;
                3'd1:    k = EL_WBYTE;
                3'd2:    k = EL_WBYTE;
                3'd3:    k = EL_WBYTE;
                3'd4:    k = EL_WBYTE;
                default: k = EL_STOP;
            endcase
        end
        return k;
    endfunction

    function automatic eng_state_t begin_element(input eng_state_t s_in,
                                                 input logic [6:0] dev,
                                                 input logic [7:0] tpu);
        eng_state_t s;
        logic [7:0] addr;
        s    = s_in;
        addr = {dev, 1'b0};
        case (plan_kind(s.is_read, s.byte_index))
            EL_START: begin
                s.sda_drive   = 1'b1;
                s.sda         = 1'b1;
                s.phase       = PH_S0;
                s.delay_count = phase_ticks(UNITS_2, tpu);
            end
            EL_WBYTE: begin
                if (s.byte_index == SLOT_ADDR) begin
                    s.shift_byte = addr;
                end else if (s.byte_index == SLOT_REG) begin
                    s.shift_byte = s.latched_register;
                end else if (s.byte_index == SLOT_RADDR && s.is_read) begin
                    s.shift_byte = addr | 8'd1;
                end else if (s.byte_index == SLOT_HIGH) begin
                    s.shift_byte = s.latched_value[15:8];
                end else begin
                    s.shift_byte = s.latched_value[7:0];
                end
                s.bit_index   = 4'd0;
                s.sda_drive   = 1'b1;
                s.scl         = 1'b0;
                s.phase       = PH_B0;
                s.delay_count = phase_ticks(UNITS_1, tpu);
            end
            EL_RBYTE: begin
                s.shift_byte  = 8'd0;
                s.bit_index   = 4'd0;
                s.sda_drive   = 1'b0;
                s.scl         = 1'b0;
                s.phase       = PH_R0;
                s.delay_count = phase_ticks(UNITS_2, tpu);
            end
            default: begin
                s.sda_drive   = 1'b1;
                s.scl         = 1'b0;
                s.phase       = PH_P0;
                s.delay_count = phase_ticks(UNITS_2, tpu);
            end
        endcase
        return s;
    endfunction

    // Leave the phase that just ran out and set up the following one
    function automatic eng_state_t advance(input eng_state_t s_in, input logic sda_bit,
                                           input logic [6:0] dev, input logic [7:0] tpu);
        eng_state_t s;
        s = s_in;
        case (s.phase)
            PH_S0: begin s.scl = 1'b1; s.phase = PH_S1; s.delay_count = phase_ticks(UNITS_2, tpu); end
            PH_S1: begin s.sda = 1'b0; s.phase = PH_S2; s.delay_count = phase_ticks(UNITS_2, tpu); end
            PH_S2: begin s.scl = 1'b0; s.phase = PH_S3; s.delay_count = phase_ticks(UNITS_6, tpu); end
            PH_B0: begin
                s.sda         = s.shift_byte[7];
                s.shift_byte  = {s.shift_byte[6:0], 1'b0};
                s.phase       = PH_B1;
                s.delay_count = phase_ticks(UNITS_1, tpu);
            end
            PH_B1: begin s.scl = 1'b1; s.phase = PH_B2; s.delay_count = phase_ticks(UNITS_2, tpu); end
            PH_B2: begin
                s.bit_index = s.bit_index + 4'd1;
                s.scl       = 1'b0;
                if (s.bit_index < 4'd8) begin
                    s.phase       = PH_B0;
                    s.delay_count = phase_ticks(UNITS_1, tpu);
                end else begin
                    s.sda_drive   = 1'b0;
                    s.phase       = PH_A0;
                    s.delay_count = phase_ticks(UNITS_2, tpu);
                end
            end
            PH_A0: begin s.scl = 1'b1; s.phase = PH_A1; s.delay_count = phase_ticks(UNITS_2, tpu); end
            PH_A1: begin s.scl = 1'b0; s.phase = PH_A2; s.delay_count = phase_ticks(UNITS_1, tpu); end
            PH_A2: begin
                s.sda         = 1'b1;
                s.sda_drive   = 1'b1;
                s.phase       = PH_A3;
                s.delay_count = phase_ticks(UNITS_6, tpu);
            end
            PH_R0: begin s.scl = 1'b1; s.phase = PH_R1; s.delay_count = phase_ticks(UNITS_2, tpu); end
            PH_R1: begin
                s.shift_byte = {s.shift_byte[6:0], sda_bit};
                s.bit_index  = s.bit_index + 4'd1;
                s.scl        = 1'b0;
                if (s.bit_index < 4'd8) begin
                    s.phase       = PH_R0;
                    s.delay_count = phase_ticks(UNITS_2, tpu);
                end else begin
                    if (s.byte_index == SLOT_RDHIGH) begin
                        s.latched_value = {s.shift_byte, 8'd0};
                    end else begin
                        s.latched_value[7:0] = s.shift_byte;
                    end
                    s.sda         = 1'b0;
                    s.sda_drive   = 1'b1;
                    s.phase       = PH_Q0;
                    s.delay_count = phase_ticks(UNITS_2, tpu);
                end
            end
            PH_Q0: begin
                // NACK after the low byte, ACK after the high byte
                s.sda         = (s.byte_index == SLOT_RDLOW);
                s.phase       = PH_Q1;
                s.delay_count = phase_ticks(UNITS_2, tpu);
            end
            PH_Q1: begin s.scl = 1'b1; s.phase = PH_Q2; s.delay_count = phase_ticks(UNITS_2, tpu); end
            PH_Q2: begin s.scl = 1'b0; s.phase = PH_Q3; s.delay_count = phase_ticks(UNITS_2, tpu); end
            PH_P0: begin s.sda = 1'b0; s.phase = PH_P1; s.delay_count = phase_ticks(UNITS_2, tpu); end
            PH_P1: begin s.scl = 1'b1; s.phase = PH_P2; s.delay_count = phase_ticks(UNITS_2, tpu); end
            PH_P2: begin s.sda = 1'b1; s.phase = PH_P3; s.delay_count = phase_ticks(UNITS_2, tpu); end
            PH_P3: begin
                if (s.is_read) begin
                    s.captured_value = s.latched_value;
                end
                s.phase       = PH_IDLE;
                s.delay_count = 11'd0;
            end
            PH_S3, PH_A3, PH_Q3: begin
                s.byte_index = s.byte_index + 3'd1;
                s = begin_element(s, dev, tpu);
            end
            default: begin
                s.phase       = PH_IDLE;
                s.delay_count = 11'd0;
            end
        endcase
        return s;
    endfunction

    always_comb begin
        logic req;
        eng_state_t s;
        req    = (item.operation == OP_WRITE) || (item.operation == OP_READ);
        s      = state_reg;
        result = '0;

        if (state_reg.phase == PH_IDLE) begin
            if (req) begin
                s.is_read          = (item.operation == OP_READ);
                s.latched_register = item.reg_address;
                s.latched_value    = s.is_read ? 16'd0 : item.write_value;
                s.byte_index       = 3'd0;
                s = begin_element(s, dev_addr, ticks_per_us);
            end
        end else begin
            result.request_dropped = req;
        end

        result.scl_level = s.scl;
        result.sda_level = s.sda;
        result.sda_drive = s.sda_drive;

        if (s.phase != PH_IDLE) begin
            result.busy_res = 1'b1;
            if (s.delay_count > 11'd1) begin
                s.delay_count = s.delay_count - 11'd1;
            end else begin
                result.done_res = (s.phase == PH_P3);
                s = advance(s, item.sda_in, dev_addr, ticks_per_us);
            end
        end

        result.read_value = s.captured_value;
        state_next        = s;
    end

    // All-zero state is idle with pins low and released
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= '0;
        end else if (take) begin
            state_reg <= state_next;
        end
    end

endmodule

// File: rtl/core/i2crm_out_stage.sv
// ----------------------------------------------------------------------------
// i2crm_out_stage
// Result register: holds one result beat until the sink takes it.
// ----------------------------------------------------------------------------
module i2crm_out_stage (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  load,
    input  i2crm_pkg::i2crm_out_t data,
    output logic                  space,
    output logic                  m_valid,
    input  logic                  m_ready,
    output i2crm_pkg::i2crm_out_t m_data
);
    import i2crm_pkg::*;

    logic       valid_reg;
    logic       valid_next;
    i2crm_out_t data_reg;

    assign space      = !valid_reg || m_ready;
    assign valid_next = load || (valid_reg && !m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= data;
        end
    end

    assign m_valid = valid_reg;
    assign m_data  = data_reg;

endmodule

// File: rtl/core/i2crm_checker.sv
// ----------------------------------------------------------------------------
// i2crm_checker
// Port-level checks of the register master, bound to the top level.
// ----------------------------------------------------------------------------
module i2crm_checker (
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  m_valid,
    input logic                  m_ready,
    input i2crm_pkg::i2crm_out_t m_data
);
    import i2crm_pkg::*;

    // A stalled result beat holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result beat changed while stalled");

    // The finishing tick is part of the transaction
    a_done_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.done_res |-> m_data.busy_res)
        else $error("done without busy");

    // A request is only dropped while a transaction runs
    a_drop_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.request_dropped |-> m_data.busy_res)
        else $error("request dropped while idle");

    // Reset empties the result register
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

endmodule

bind i2c_register_master_unit i2crm_checker u_i2crm_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
